### sv/tcpd_pkg.sv
// Package for the two-class priority dispatcher.
// Holds the queue entry type, queue status struct and the function and status codes.
// No dependencies.
`default_nettype none

package tcpd_pkg;

  localparam int NUM_W = 16;
  localparam int ID_W  = 30;
  localparam int AGE_W = 8;
  localparam int GAP_W = 8;
  localparam logic [GAP_W-1:0] AGE_GAP_RESET = 8'd5;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [AGE_W-1:0] age;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef enum logic [1:0] {
    FN_NORMAL   = 2'd0,
    FN_PRIO     = 2'd1,
    FN_DISPATCH = 2'd2,
    FN_UNKNOWN  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_FULL     = 3'd1,
    ST_SERVED   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

endpackage

`default_nettype wire

### sv/tcpd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module tcpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/tcpd_queue.sv
// Circular request queue: head pointer and fill count around one entry RAM.
// Depends on tcpd_pkg and tcpd_ram.
`default_nettype none

module tcpd_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire logic            push,
  input  tcpd_pkg::entry_t     push_data,
  input  wire logic            pop,
  output tcpd_pkg::entry_t     head_data,
  output tcpd_pkg::qstat_t     stat
);

  import tcpd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum;
  logic [PTR_W-1:0] tail;

  always_comb begin
    sum = SUM_W'(head_r) + SUM_W'(cnt_r);
    if (sum >= SUM_W'(DEPTH)) begin
      tail = PTR_W'(sum - SUM_W'(DEPTH));
    end else begin
      tail = PTR_W'(sum);
    end
    stat.empty = (cnt_r == '0);
    stat.full  = (cnt_r == CNT_W'(DEPTH));
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop) begin
      cnt_nxt = cnt_r - 1'b1;
      if (head_r == PTR_W'(DEPTH - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  tcpd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail),
    .wdata (push_data),
    .re    (rd_en),
    .raddr (head_r),
    .rdata (head_data)
  );

endmodule

`default_nettype wire

### sv/two_class_priority_dispatcher.sv
// Two-class priority dispatcher: normal and priority request queues feeding server slots.
// Two steps per transaction: accept and head reads (S_IDLE), then decide and write back (S_EXEC).
// No new transaction is taken until the last is written back, as the RAM read is registered.
// The result is registered as S_EXEC completes; S_EXEC waits while an earlier result is stalled.
// Synchronous active-low reset empties both queues, idles all servers and restores age_gap.
`default_nettype none

module two_class_priority_dispatcher #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SERVERS     = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // server_index[3:0], client_id[33:4], client_age[41:34], zero fill above
  input  wire logic [47:0] in_tdata,
  // func[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // assigned_valid[0], assigned_id[30:1], assigned_age[38:31],
  // assigned_from_priority[39], arrival_number[55:40]
  output logic [55:0]      out_tdata,
  // status[2:0]
  output logic [2:0]       out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  import tcpd_pkg::*;

  localparam int SIDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         func_r;
  logic [3:0]         sidx_r;
  logic [ID_W-1:0]    id_r;
  logic [AGE_W-1:0]   age_r;
  logic [GAP_W-1:0]   age_gap_r;
  logic [NUM_W-1:0]   arr_r, arr_nxt;
  logic [SERVERS-1:0] busy_r, busy_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         status_r, status_nxt;
  logic               avalid_r, avalid_nxt;
  logic [ID_W-1:0]    aid_r, aid_nxt;
  logic [AGE_W-1:0]   aage_r, aage_nxt;
  logic               fromp_r, fromp_nxt;
  logic [NUM_W-1:0]   anum_r, anum_nxt;

  logic               accept, fire;
  logic               is_enq, qsel, sel_full, srv_ok, have, take_normal;
  logic [SIDX_W-1:0]  s_idx;
  logic [NUM_W-1:0]   stamp, diff;
  logic               push_n, push_p, pop_n, pop_p;
  entry_t             new_entry, n_head, p_head, pick;
  qstat_t             n_stat, p_stat;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign fire       = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {anum_r, fromp_r, aage_r, aid_r, avalid_r};

  always_comb begin
    is_enq   = (func_r == FN_NORMAL) || (func_r == FN_PRIO);
    qsel     = (func_r == FN_PRIO);
    sel_full = qsel ? p_stat.full : n_stat.full;
    stamp    = arr_r + 1'b1;
    srv_ok   = (func_r == FN_DISPATCH) && (sidx_r != 4'd0) && (sidx_r <= 4'(SERVERS));
    s_idx    = SIDX_W'(sidx_r - 4'd1);
    have     = !(p_stat.empty && n_stat.empty);
    diff     = p_head.num - n_head.num;
    if (p_stat.empty) begin
      take_normal = 1'b1;
    end else if (n_stat.empty) begin
      take_normal = 1'b0;
    end else begin
      take_normal = !diff[NUM_W-1] && (diff > NUM_W'(age_gap_r));
    end
    pick = take_normal ? n_head : p_head;

    new_entry.num = stamp;
    new_entry.age = age_r;
    new_entry.id  = id_r;

    push_n = fire && is_enq && !qsel && !sel_full;
    push_p = fire && is_enq && qsel && !sel_full;
    pop_n  = fire && srv_ok && have && take_normal;
    pop_p  = fire && srv_ok && have && !take_normal;

    state_nxt     = state_r;
    arr_nxt       = arr_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    avalid_nxt    = avalid_r;
    aid_nxt       = aid_r;
    aage_nxt      = aage_r;
    fromp_nxt     = fromp_r;
    anum_nxt      = anum_r;

    if (accept) begin
      state_nxt = S_EXEC;
    end
    if (fire) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      status_nxt    = ST_NOTFOUND;
      avalid_nxt    = 1'b0;
      aid_nxt       = '0;
      aage_nxt      = '0;
      fromp_nxt     = 1'b0;
      anum_nxt      = '0;
      if (is_enq) begin
        if (sel_full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_ENQUEUED;
          anum_nxt   = stamp;
          arr_nxt    = stamp;
        end
      end else if (srv_ok) begin
        status_nxt      = busy_r[s_idx] ? ST_SERVED : ST_EMPTY;
        busy_nxt[s_idx] = have;
        if (have) begin
          avalid_nxt = 1'b1;
          aid_nxt    = pick.id;
          aage_nxt   = pick.age;
          fromp_nxt  = !take_normal;
          anum_nxt   = pick.num;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      arr_r       <= '0;
      busy_r      <= '0;
      age_gap_r   <= AGE_GAP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      arr_r       <= arr_nxt;
      busy_r      <= busy_nxt;
      if (cfg_valid && cfg_ready) begin
        age_gap_r <= cfg_data;
      end
    end
    status_r <= status_nxt;
    avalid_r <= avalid_nxt;
    aid_r    <= aid_nxt;
    aage_r   <= aage_nxt;
    fromp_r  <= fromp_nxt;
    anum_r   <= anum_nxt;
    if (accept) begin
      func_r <= in_tuser;
      sidx_r <= in_tdata[3:0];
      id_r   <= in_tdata[33:4];
      age_r  <= in_tdata[41:34];
    end
  end

  tcpd_queue #(.DEPTH (QUEUE_DEPTH)) u_normal_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .push      (push_n),
    .push_data (new_entry),
    .pop       (pop_n),
    .head_data (n_head),
    .stat      (n_stat)
  );

  tcpd_queue #(.DEPTH (QUEUE_DEPTH)) u_prio_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .push      (push_p),
    .push_data (new_entry),
    .pop       (pop_p),
    .head_data (p_head),
    .stat      (p_stat)
  );

endmodule

`default_nettype wire

### sv/tcpd_checker.sv
// Port-level checker for the two-class priority dispatcher, bound to the top level.
// Depends on tcpd_pkg for the status codes.
`default_nettype none

module tcpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [47:0] in_tdata,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [7:0]  cfg_data
);

  import tcpd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  a_no_assign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ENQUEUED || out_tuser == ST_FULL ||
                   out_tuser == ST_NOTFOUND) |-> !out_tdata[0] && !out_tdata[39])
    else $error("assignment reported on a non-dispatch result");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_NOTFOUND)
    |-> out_tdata[55:40] == 16'd0)
    else $error("arrival number given on a dropped or unknown request");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[39:1] == 39'd0)
    else $error("client fields set without an assignment");

endmodule

bind two_class_priority_dispatcher tcpd_checker u_tcpd_checker (.*);

`default_nettype wire

### dv/tb_two_class_priority_dispatcher.sv
// Self-checking testbench for two_class_priority_dispatcher: a stream driver and monitor with
// random idling, a behavioural model of both queues, the aging rule and the servers.
// Depends on tcpd_pkg and the dispatcher RTL only.
`default_nettype none

module tb_two_class_priority_dispatcher;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpd_pkg::*;

  localparam int QDEPTH       = 16;
  localparam int N_SERVERS    = 4;
  localparam int WDOG_LIMIT   = 2000;
  localparam int SETTLE       = 6;

  typedef struct packed {
    func_t             func;
    logic [3:0]        server;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
    logic              from_prio;
    logic [NUM_W-1:0]  num;
  } result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;

  two_class_priority_dispatcher #(
    .QUEUE_DEPTH (QDEPTH),
    .SERVERS     (N_SERVERS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Model state.
  entry_t           normal_fifo[$];
  entry_t           prio_fifo[$];
  logic [NUM_W-1:0] arrival_ctr = '0;
  logic [GAP_W-1:0] gap_model   = AGE_GAP_RESET;
  logic             server_busy[N_SERVERS];

  req_t    pending_reqs[$];
  result_t expected_results[$];

  int stall_pct   = 20;
  int in_gap      = 0;
  int out_gap     = 0;
  int errors      = 0;
  int n_requests  = 0;
  int n_checked   = 0;
  int n_dropped   = 0;
  int n_aged      = 0;
  int n_gap_set   = 0;
  int idle_cycles = 0;

  function automatic result_t serve_request(req_t r);
    result_t          res;
    entry_t           e;
    logic [NUM_W-1:0] lead;
    logic             take_prio;
    res        = '0;
    res.status = ST_NOTFOUND;
    case (r.func)
      FN_NORMAL, FN_PRIO: begin
        e.id  = r.id;
        e.age = r.age;
        e.num = arrival_ctr + 16'd1;
        if ((r.func == FN_PRIO ? prio_fifo.size() : normal_fifo.size()) >= QDEPTH) begin
          res.status = ST_FULL;
          n_dropped++;
        end else begin
          if (r.func == FN_PRIO) prio_fifo = {prio_fifo, e};
          else normal_fifo = {normal_fifo, e};
          arrival_ctr = e.num;
          res.status  = ST_ENQUEUED;
          res.num     = e.num;
        end
      end
      FN_DISPATCH: begin
        if (r.server >= 1 && r.server <= N_SERVERS) begin
          res.status = server_busy[r.server-1] ? ST_SERVED : ST_EMPTY;
          if (prio_fifo.size() == 0 && normal_fifo.size() == 0) begin
            server_busy[r.server-1] = 1'b0;
          end else begin
            if (prio_fifo.size() == 0) begin
              take_prio = 1'b0;
            end else if (normal_fifo.size() == 0) begin
              take_prio = 1'b1;
            end else begin
              lead      = prio_fifo[0].num - normal_fifo[0].num;
              take_prio = !(lead < 16'h8000 && lead > gap_model);
              if (!take_prio) n_aged++;
            end
            e = take_prio ? prio_fifo.pop_front() : normal_fifo.pop_front();
            server_busy[r.server-1] = 1'b1;
            res.valid     = 1'b1;
            res.id        = e.id;
            res.age       = e.age;
            res.from_prio = take_prio;
            res.num       = e.num;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Driver: presents the oldest pending request and holds it until the transaction completes.
  always @(posedge clk) begin : driver
    result_t pred;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        pred = serve_request(pending_reqs.pop_front());
        expected_results = {expected_results, pred};
        n_requests++;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0 && stall_pct != 0 &&
                   $urandom_range(99) < stall_pct) begin
        in_gap = $urandom_range(7);
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {6'd0, pending_reqs[0].age, pending_reqs[0].id, pending_reqs[0].server};
        in_tuser  <= pending_reqs[0].func;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual status %0d data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          check_field("status", want.status, out_tuser);
          check_field("assigned_valid", want.valid, out_tdata[0]);
          check_field("assigned_id", want.id, out_tdata[30:1]);
          check_field("assigned_age", want.age, out_tdata[38:31]);
          check_field("assigned_from_priority", want.from_prio, out_tdata[39]);
          check_field("arrival_number", want.num, out_tdata[55:40]);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_gap = $urandom_range(7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, WDOG_LIMIT, expected_results.size());
        $display("[two_class_priority_dispatcher] ERROR");
        $finish;
      end
    end
  end

  task automatic add_req(func_t f, logic [3:0] s, logic [ID_W-1:0] id, logic [AGE_W-1:0] age);
    req_t r;
    r.func   = f;
    r.server = s;
    r.id     = id;
    r.age    = age;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic add_random_req(int w_norm, int w_prio, int w_disp);
    int               pick;
    int               bad;
    logic [3:0]       s;
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
    pick = $urandom_range(w_norm + w_prio + w_disp + 5, 0);
    s    = 4'($urandom_range(15));
    id   = ID_W'($urandom_range(1000000000));
    age  = AGE_W'($urandom_range(130));
    if (pick < w_norm)
      add_req(FN_NORMAL, s, id, age);
    else if (pick < w_norm + w_prio)
      add_req(FN_PRIO, s, id, age);
    else if (pick < w_norm + w_prio + w_disp)
      add_req(FN_DISPATCH, 4'($urandom_range(N_SERVERS, 1)), id, age);
    else if (pick < w_norm + w_prio + w_disp + 3) begin
      bad = $urandom_range(11);
      add_req(FN_DISPATCH, bad == 0 ? 4'd0 : 4'(bad + N_SERVERS), id, age);
    end else
      add_req(FN_UNKNOWN, s, id, age);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gap(logic [GAP_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gap_model = v;
    n_gap_set++;
  endtask

  initial begin : stimulus
    logic [GAP_W-1:0] phase_gap[6];
    for (int i = 0; i < N_SERVERS; i++) server_busy[i] = 1'b0;
    phase_gap = '{8'd255, 8'd1, 8'd128, 8'd0, 8'd254, 8'($urandom_range(254, 2))};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the reset value of age_gap.
    add_req(FN_UNKNOWN, 4'd2, 30'h3FFFFFFF, 8'd130);
    add_req(FN_DISPATCH, 4'd0, 30'd0, 8'd0);
    add_req(FN_DISPATCH, 4'd5, 30'd0, 8'd0);
    add_req(FN_DISPATCH, 4'd15, 30'd1000000000, 8'd130);
    add_req(FN_DISPATCH, 4'd1, 30'd0, 8'd0);
    add_req(FN_PRIO, 4'd15, 30'd1000000000, 8'd130);
    add_req(FN_PRIO, 4'd0, 30'd0, 8'd0);
    for (int i = 0; i < QDEPTH - 1; i++)
      add_req(FN_PRIO, 4'($urandom_range(15)), ID_W'($urandom_range(1000000000)),
              AGE_W'($urandom_range(130)));
    add_req(FN_NORMAL, 4'd9, 30'd123456789, 8'd0);
    add_req(FN_DISPATCH, 4'd4, 30'd0, 8'd0);
    add_req(FN_DISPATCH, 4'd4, 30'd0, 8'd0);
    wait_drained();

    write_gap(8'd0);
    repeat (250) add_random_req($urandom_range(40, 10), $urandom_range(40, 10),
                                $urandom_range(50, 20));
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_gap(phase_gap[p]);
      if (p == 5) stall_pct = 0;
      repeat (217) add_random_req($urandom_range(40, 5), $urandom_range(40, 5),
                                  $urandom_range(50, 15));
      wait_drained();
    end

    $display("Checked %0d results for %0d requests with %0d writes of age_gap.",
             n_checked, n_requests, n_gap_set);
    $display("Full-queue drops: %0d, normal requests promoted by aging: %0d.",
             n_dropped, n_aged);
    if (errors == 0)
      $display("[two_class_priority_dispatcher] OK");
    else
      $display("[two_class_priority_dispatcher] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
